// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the execute stage.
// Every macro takes a label, a clock, an active-low reset and the expressions to check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/cab_pkg.sv =====
// Shared types and operation codes for the ALU and branch execute stage.
// No dependencies; the ALU, sequencer, top level and testbench use it by scoped names.
package cab_pkg;

	// Operation codes carried in req_type.
	localparam logic [4:0] OP_ADD   = 5'd0;
	localparam logic [4:0] OP_SUB   = 5'd1;
	localparam logic [4:0] OP_MOV   = 5'd2;
	localparam logic [4:0] OP_CMP   = 5'd3;
	localparam logic [4:0] OP_BIT   = 5'd4;
	localparam logic [4:0] OP_BIC   = 5'd5;
	localparam logic [4:0] OP_BIS   = 5'd6;
	localparam logic [4:0] OP_ADDB  = 5'd7;
	localparam logic [4:0] OP_SUBB  = 5'd8;
	localparam logic [4:0] OP_MOVB  = 5'd9;
	localparam logic [4:0] OP_CMPB  = 5'd10;
	localparam logic [4:0] OP_BR    = 5'd11;
	localparam logic [4:0] OP_BNE   = 5'd12;
	localparam logic [4:0] OP_BEQ   = 5'd13;
	localparam logic [4:0] OP_BGE   = 5'd14;
	localparam logic [4:0] OP_BLT   = 5'd15;
	localparam logic [4:0] OP_BGT   = 5'd16;
	localparam logic [4:0] OP_BLE   = 5'd17;
	localparam logic [4:0] OP_BPL   = 5'd18;
	localparam logic [4:0] OP_BMI   = 5'd19;
	localparam logic [4:0] OP_BHI   = 5'd20;
	localparam logic [4:0] OP_BLOS  = 5'd21;
	localparam logic [4:0] OP_BVC   = 5'd22;
	localparam logic [4:0] OP_BVS   = 5'd23;
	localparam logic [4:0] OP_BCC   = 5'd24;
	localparam logic [4:0] OP_BCS   = 5'd25;
	localparam logic [4:0] OP_HALT  = 5'd26;
	localparam logic [4:0] OP_WAIT  = 5'd27;
	localparam logic [4:0] OP_RESET = 5'd28;
	localparam logic [4:0] OP_NOP   = 5'd29;

	// Priority bits forced on by a halt.
	localparam logic [7:0] PRIO_MASK = 8'hE0;

	// Status word bit positions of the condition codes.
	localparam int FLAG_N = 3;
	localparam int FLAG_Z = 2;
	localparam int FLAG_V = 1;
	localparam int FLAG_C = 0;

	// Outcome of the data path for one operand operation.
	typedef struct packed {
		logic [15:0] value;
		logic        write_back;
		logic [3:0]  nzvc;
	} alu_res_t;

	// Program counter and status outcome of one instruction.
	typedef struct packed {
		logic [15:0] next_pc;
		logic        taken;
		logic [7:0]  status;
	} seq_res_t;

endpackage

// ===== sv/cab_alu.sv =====
// Operand data path: word and byte add, subtract, compare, move and bit operations.
// Depends on cab_pkg for operation codes and the alu_res_t result type.
module cab_alu (
	input  logic [4:0]         op,
	input  logic [15:0]        src,
	input  logic [15:0]        dst,
	input  logic               c_in,
	output cab_pkg::alu_res_t  res
);

	logic        is_byte;
	logic        is_sub;
	logic [15:0] mask;
	logic [15:0] s;
	logic [15:0] d;
	logic [16:0] sum;
	logic [15:0] sub_a;
	logic [15:0] sub_b;
	logic [16:0] diff;
	logic [15:0] r;
	logic        sgn_s;
	logic        sgn_d;
	logic        sgn_r;
	logic        sgn_a;
	logic        sgn_b;
	logic        v;
	logic        c;
	logic        wb;

	// Operand width selection and the shared adder and subtractor.
	always_comb begin
		is_byte = op inside {[cab_pkg::OP_ADDB:cab_pkg::OP_CMPB]};
		is_sub  = (op == cab_pkg::OP_SUB) || (op == cab_pkg::OP_SUBB);
		mask    = is_byte ? 16'h00FF : 16'hFFFF;
		s       = src & mask;
		d       = dst & mask;
		sum     = {1'b0, s} + {1'b0, d};
		// SUB takes dst - src, CMP takes src - dst.
		sub_a   = is_sub ? d : s;
		sub_b   = is_sub ? s : d;
		diff    = {1'b0, sub_a} - {1'b0, sub_b};
	end

	// Result value, write flag and the carry and overflow codes.
	always_comb begin
		r  = 16'h0000;
		v  = 1'b0;
		c  = c_in;
		wb = 1'b0;
		case (op)
			cab_pkg::OP_ADD, cab_pkg::OP_ADDB: begin
				r  = sum[15:0] & mask;
				c  = is_byte ? sum[8] : sum[16];
				wb = 1'b1;
			end
			cab_pkg::OP_SUB, cab_pkg::OP_SUBB: begin
				r  = diff[15:0] & mask;
				c  = diff[16];
				wb = 1'b1;
			end
			cab_pkg::OP_CMP, cab_pkg::OP_CMPB: begin
				r  = diff[15:0] & mask;
				c  = diff[16];
			end
			cab_pkg::OP_MOV, cab_pkg::OP_MOVB: begin
				r  = s;
				wb = 1'b1;
			end
			cab_pkg::OP_BIT: begin
				r  = s & d;
			end
			cab_pkg::OP_BIC: begin
				r  = d & ~s;
				wb = 1'b1;
			end
			cab_pkg::OP_BIS: begin
				r  = d | s;
				wb = 1'b1;
			end
			default: begin
				r  = 16'h0000;
			end
		endcase

		// Sign bits sit at bit 7 for byte operations and bit 15 for words.
		sgn_s = is_byte ? s[7] : s[15];
		sgn_d = is_byte ? d[7] : d[15];
		sgn_r = is_byte ? r[7] : r[15];
		sgn_a = is_byte ? sub_a[7] : sub_a[15];
		sgn_b = is_byte ? sub_b[7] : sub_b[15];

		case (op)
			cab_pkg::OP_ADD, cab_pkg::OP_ADDB: begin
				v = (sgn_s == sgn_d) && (sgn_r != sgn_s);
			end
			cab_pkg::OP_SUB, cab_pkg::OP_SUBB, cab_pkg::OP_CMP, cab_pkg::OP_CMPB: begin
				v = (sgn_a != sgn_b) && (sgn_a != sgn_r);
			end
			default: begin
				v = 1'b0;
			end
		endcase
	end

	// Pack the outcome; the destination value reads as zero when nothing is written.
	always_comb begin
		res.value      = wb ? r : 16'h0000;
		res.write_back = wb;
		res.nzvc       = {sgn_r, (r == 16'h0000), v, c};
	end

endmodule

// ===== sv/cab_seq.sv =====
// Program counter and status sequencing: branch conditions, halt, wait and reset.
// Depends on cab_pkg for operation codes, flag positions and the result structs.
module cab_seq (
	input  logic [4:0]         op,
	input  logic signed [7:0]  adj,
	input  logic [15:0]        pc,
	input  logic [7:0]         status,
	input  cab_pkg::alu_res_t  alu,
	output cab_pkg::seq_res_t  res
);

	logic        fn;
	logic        fz;
	logic        fv;
	logic        fc;
	logic        cond;
	logic [15:0] adj_ext;
	logic [15:0] br_off;
	logic [15:0] pc_plus2;
	logic [15:0] byte_pc;

	// Branch condition from the current condition codes.
	always_comb begin
		fn = status[cab_pkg::FLAG_N];
		fz = status[cab_pkg::FLAG_Z];
		fv = status[cab_pkg::FLAG_V];
		fc = status[cab_pkg::FLAG_C];
		case (op)
			cab_pkg::OP_BR:   cond = 1'b1;
			cab_pkg::OP_BNE:  cond = !fz;
			cab_pkg::OP_BEQ:  cond = fz;
			cab_pkg::OP_BGE:  cond = (fn == fv);
			cab_pkg::OP_BLT:  cond = (fn != fv);
			cab_pkg::OP_BGT:  cond = !(fz || (fn != fv));
			cab_pkg::OP_BLE:  cond = fz || (fn != fv);
			cab_pkg::OP_BPL:  cond = !fn;
			cab_pkg::OP_BMI:  cond = fn;
			cab_pkg::OP_BHI:  cond = !(fc || fz);
			cab_pkg::OP_BLOS: cond = fc || fz;
			cab_pkg::OP_BVC:  cond = !fv;
			cab_pkg::OP_BVS:  cond = fv;
			cab_pkg::OP_BCC:  cond = !fc;
			cab_pkg::OP_BCS:  cond = fc;
			default:          cond = 1'b0;
		endcase
	end

	// Candidate program counter values.
	always_comb begin
		adj_ext  = {{8{adj[7]}}, adj};
		br_off   = {{7{adj[7]}}, adj, 1'b0};
		pc_plus2 = pc + 16'd2;
		// Byte operations step by the adjust plus one and then round up to an even address.
		byte_pc  = pc + adj_ext + 16'd1;
		byte_pc  = byte_pc + {15'd0, byte_pc[0]};
	end

	// Select the next program counter and status word.
	always_comb begin
		res.next_pc = pc_plus2;
		res.taken   = 1'b0;
		res.status  = status;
		case (op)
			cab_pkg::OP_ADD, cab_pkg::OP_SUB, cab_pkg::OP_MOV, cab_pkg::OP_CMP,
			cab_pkg::OP_BIT, cab_pkg::OP_BIC, cab_pkg::OP_BIS: begin
				res.next_pc = pc + adj_ext + 16'd2;
				res.status  = {status[7:4], alu.nzvc};
			end
			cab_pkg::OP_ADDB, cab_pkg::OP_SUBB, cab_pkg::OP_MOVB, cab_pkg::OP_CMPB: begin
				res.next_pc = byte_pc;
				res.status  = {status[7:4], alu.nzvc};
			end
			cab_pkg::OP_BR, cab_pkg::OP_BNE, cab_pkg::OP_BEQ, cab_pkg::OP_BGE,
			cab_pkg::OP_BLT, cab_pkg::OP_BGT, cab_pkg::OP_BLE, cab_pkg::OP_BPL,
			cab_pkg::OP_BMI, cab_pkg::OP_BHI, cab_pkg::OP_BLOS, cab_pkg::OP_BVC,
			cab_pkg::OP_BVS, cab_pkg::OP_BCC, cab_pkg::OP_BCS: begin
				res.next_pc = cond ? (pc_plus2 + br_off) : pc_plus2;
				res.taken   = cond;
			end
			cab_pkg::OP_HALT: begin
				res.status  = status | cab_pkg::PRIO_MASK;
			end
			cab_pkg::OP_WAIT: begin
				res.next_pc = pc;
			end
			cab_pkg::OP_RESET: begin
				res.next_pc = 16'h0000;
			end
			default: begin
				// NOP and the unused codes just step past the instruction.
				res.next_pc = pc_plus2;
			end
		endcase
	end

endmodule

// ===== sv/cpu_alu_and_branch_execute.sv =====
// Execute stage of a 16-bit minicomputer CPU with ALU, condition codes and branches.
// Input channel: in_valid / in_stall with req_type, src_value, dst_value, pc_adjust.
// Output channel: out_valid / out_stall with result_value, write_back, next_pc,
// branch_taken and status_out. A beat moves when valid is high and stall is low.
// Each accepted beat lands in an input register; the ALU and the sequencer work on
// it there, and the outcome is loaded into the output register when it can advance,
// where the program counter and status word are updated as well.
// One beat is taken every cycle while the receiver does not stall; the rate is set
// by the combinational path from the input register through the ALU adders, the
// flag logic and the sequencer into the output register.
// While the receiver stalls, the output register holds its beat and the input
// register holds one more; in_stall rises only when both are full.
// Reset clears the program counter, the status word and both valid bits.
// Depends on cab_pkg, cab_alu and cab_seq.
module cpu_alu_and_branch_execute (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [4:0]         req_type,
	input  logic [15:0]        src_value,
	input  logic [15:0]        dst_value,
	input  logic signed [7:0]  pc_adjust,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        result_value,
	output logic               write_back,
	output logic [15:0]        next_pc,
	output logic               branch_taken,
	output logic [7:0]         status_out
);

	logic               valid_s1;
	logic [4:0]         op_s1;
	logic [15:0]        src_s1;
	logic [15:0]        dst_s1;
	logic signed [7:0]  adj_s1;
	logic               valid_s2;
	logic [15:0]        value_s2;
	logic               wb_s2;
	logic [15:0]        pc_s2;
	logic               taken_s2;
	logic [7:0]         status_s2;
	logic [15:0]        pc_q;
	logic [7:0]         status_q;
	logic               advance;
	logic               in_accept;
	cab_pkg::alu_res_t  alu_res;
	cab_pkg::seq_res_t  seq_res;

	// The input register moves on whenever the output register is empty or draining.
	assign advance   = !valid_s2 || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_s1  <= req_type;
			src_s1 <= src_value;
			dst_s1 <= dst_value;
			adj_s1 <= pc_adjust;
		end
	end

	// Operand data path.
	cab_alu u_alu (
		.op    (op_s1),
		.src   (src_s1),
		.dst   (dst_s1),
		.c_in  (status_q[cab_pkg::FLAG_C]),
		.res   (alu_res)
	);

	// Program counter and status sequencing.
	cab_seq u_seq (
		.op     (op_s1),
		.adj    (adj_s1),
		.pc     (pc_q),
		.status (status_q),
		.alu    (alu_res),
		.res    (seq_res)
	);

	// Architectural state follows each beat as it enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= 16'h0000;
			status_q <= 8'h00;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				pc_q     <= seq_res.next_pc;
				status_q <= seq_res.status;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			value_s2  <= alu_res.value;
			wb_s2     <= alu_res.write_back;
			pc_s2     <= seq_res.next_pc;
			taken_s2  <= seq_res.taken;
			status_s2 <= seq_res.status;
		end
	end

	assign out_valid    = valid_s2;
	assign result_value = value_s2;
	assign write_back   = wb_s2;
	assign next_pc      = pc_s2;
	assign branch_taken = taken_s2;
	assign status_out   = status_s2;

endmodule

// ===== sv/cab_checker.sv =====
// Port-level checks for the execute stage, bound to the top level below.
// Depends on assert_macros.svh and the ports of cpu_alu_and_branch_execute.
`include "assert_macros.svh"

module cab_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        result_value,
	input  logic               write_back,
	input  logic [15:0]        next_pc,
	input  logic               branch_taken,
	input  logic [7:0]         status_out
);

	// A stalled output beat stays valid and keeps its result, pc and status.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_value) && $stable(next_pc) && $stable(status_out))

	// A destination that is not written reads as zero.
	`ASSERT_SAME(a_no_wb_zero, clk, arst_n, out_valid && !write_back, result_value == 16'h0000)

	// Only branches are taken, and branches never write a destination.
	`ASSERT_SAME(a_taken_no_wb, clk, arst_n, out_valid && branch_taken, !write_back)

	// A fresh output beat after an empty cycle comes from an input beat that went straight through the input register.
	`ASSERT_SAME(a_latency, clk, arst_n, out_valid && !$past(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind cpu_alu_and_branch_execute cab_checker u_cab_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result_value (result_value),
	.write_back   (write_back),
	.next_pc      (next_pc),
	.branch_taken (branch_taken),
	.status_out   (status_out)
);

// ===== tb/tb_cpu_alu_and_branch_execute.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ALU and branch execute stage.
// Depends on cab_pkg and cpu_alu_and_branch_execute; predicts every retired beat in place.
module tb_cpu_alu_and_branch_execute;

	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 10;

	// One retired instruction as seen on the output channel.
	typedef struct packed {
		logic [15:0] value;
		logic        wb;
		logic [15:0] npc;
		logic        taken;
		logic [7:0]  psw;
	} retire_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [4:0]        req_type;
	logic [15:0]       src_value;
	logic [15:0]       dst_value;
	logic signed [7:0] pc_adjust;
	logic              out_valid;
	logic              out_stall;
	logic [15:0]       result_value;
	logic              write_back;
	logic [15:0]       next_pc;
	logic              branch_taken;
	logic [7:0]        status_out;

	// Architectural state as the predictor sees it.
	logic [15:0] arch_pc;
	logic [7:0]  arch_psw;

	retire_t retire_q[$];
	int      mismatch_count;
	int      beat_count;
	int      cycle_count;
	bit      idling;

	cpu_alu_and_branch_execute dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.src_value   (src_value),
		.dst_value   (dst_value),
		.pc_adjust   (pc_adjust),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_value(result_value),
		.write_back  (write_back),
		.next_pc     (next_pc),
		.branch_taken(branch_taken),
		.status_out  (status_out)
	);

	// Free-running 8 ns clock.
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Executes one instruction on the architectural state and returns what it retires.
	function automatic retire_t retire_instr(input logic [4:0] op, input logic [15:0] s,
			input logic [15:0] d, input logic signed [7:0] adj);
		retire_t     o;
		logic        byte_op;
		logic [4:0]  kind;
		logic [15:0] msk, sgn, sv, dv, a, b, r, offs;
		logic [16:0] sum;
		logic        n, z, v, c, cond;
		o = '0;
		byte_op = (op >= cab_pkg::OP_ADDB) && (op <= cab_pkg::OP_CMPB);
		offs = {{8{adj[7]}}, adj};
		if (op <= cab_pkg::OP_CMPB) begin
			// Byte forms reuse the word operation with an 8-bit mask.
			kind = byte_op ? op - cab_pkg::OP_ADDB : op;
			msk = byte_op ? 16'h00FF : 16'hFFFF;
			sgn = byte_op ? 16'h0080 : 16'h8000;
			sv = s & msk;
			dv = d & msk;
			c = arch_psw[cab_pkg::FLAG_C];
			v = 1'b0;
			case (kind)
				cab_pkg::OP_ADD: begin
					sum = sv + dv;
					c = sum > {1'b0, msk};
					r = sum[15:0] & msk;
					v = ((~(sv ^ dv)) & (sv ^ r) & sgn) != 16'h0;
					o.value = r;
					o.wb = 1'b1;
				end
				cab_pkg::OP_SUB, cab_pkg::OP_CMP: begin
					// SUB is dst minus src, CMP is src minus dst.
					a = (kind == cab_pkg::OP_SUB) ? dv : sv;
					b = (kind == cab_pkg::OP_SUB) ? sv : dv;
					r = (a - b) & msk;
					c = a < b;
					v = ((a ^ b) & (a ^ r) & sgn) != 16'h0;
					if (kind == cab_pkg::OP_SUB) begin
						o.value = r;
						o.wb = 1'b1;
					end
				end
				cab_pkg::OP_MOV: begin
					r = sv;
					o.value = r;
					o.wb = 1'b1;
				end
				cab_pkg::OP_BIT: begin
					r = sv & dv;
				end
				cab_pkg::OP_BIC: begin
					r = dv & ~sv & msk;
					o.value = r;
					o.wb = 1'b1;
				end
				default: begin
					r = dv | sv;
					o.value = r;
					o.wb = 1'b1;
				end
			endcase
			n = (r & sgn) != 16'h0;
			z = r == 16'h0;
			arch_psw[3:0] = {n, z, v, c};
			if (byte_op) begin
				arch_pc = arch_pc + offs + 16'd1;
				arch_pc = arch_pc + {15'd0, arch_pc[0]};
			end else begin
				arch_pc = arch_pc + offs + 16'd2;
			end
		end else if (op <= cab_pkg::OP_BCS) begin
			// Branch conditions work on the flags left by earlier instructions.
			n = arch_psw[cab_pkg::FLAG_N];
			z = arch_psw[cab_pkg::FLAG_Z];
			v = arch_psw[cab_pkg::FLAG_V];
			c = arch_psw[cab_pkg::FLAG_C];
			case (op)
				cab_pkg::OP_BR:   cond = 1'b1;
				cab_pkg::OP_BNE:  cond = !z;
				cab_pkg::OP_BEQ:  cond = z;
				cab_pkg::OP_BGE:  cond = (n == v);
				cab_pkg::OP_BLT:  cond = (n != v);
				cab_pkg::OP_BGT:  cond = !(z || (n != v));
				cab_pkg::OP_BLE:  cond = z || (n != v);
				cab_pkg::OP_BPL:  cond = !n;
				cab_pkg::OP_BMI:  cond = n;
				cab_pkg::OP_BHI:  cond = !(c || z);
				cab_pkg::OP_BLOS: cond = c || z;
				cab_pkg::OP_BVC:  cond = !v;
				cab_pkg::OP_BVS:  cond = v;
				cab_pkg::OP_BCC:  cond = !c;
				default:          cond = c;
			endcase
			arch_pc = arch_pc + 16'd2;
			if (cond) begin
				arch_pc = arch_pc + {offs[14:0], 1'b0};
				o.taken = 1'b1;
			end
		end else if (op == cab_pkg::OP_HALT) begin
			arch_pc = arch_pc + 16'd2;
			arch_psw = arch_psw | cab_pkg::PRIO_MASK;
		end else if (op == cab_pkg::OP_RESET) begin
			arch_pc = 16'd0;
		end else if (op != cab_pkg::OP_WAIT) begin
			arch_pc = arch_pc + 16'd2;
		end
		o.npc = arch_pc;
		o.psw = arch_psw;
		return o;
	endfunction

	// Sends one instruction beat, with an optional idle burst ahead of it.
	task automatic send_instr(input logic [4:0] op, input logic [15:0] s, input logic [15:0] d,
			input logic signed [7:0] adj);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		src_value <= s;
		dst_value <= d;
		pc_adjust <= adj;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		retire_q.push_back(retire_instr(op, s, d, adj));
		@(negedge clk);
	endtask

	// Operand values lean toward the sign and carry boundaries of both widths.
	function automatic logic [15:0] pick_operand();
		logic [15:0] w;
		w = 16'($urandom_range(0, 65535));
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return {w[15:8], 8'h80};
			5: return {w[15:8], 8'h7F};
			6: return {w[15:8], 8'hFF};
			7: return {w[15:8], 8'h00};
			default: return w;
		endcase
	endfunction

	// Sends a short program fragment: a flag-setting operation, a branch, both, or a control instruction.
	task automatic send_random_fragment(output int sent);
		int          pick;
		logic [4:0]  ctl;
		pick = $urandom_range(0, 19);
		sent = 0;
		if (pick < 14) begin
			send_instr(5'($urandom_range(cab_pkg::OP_ADD, cab_pkg::OP_CMPB)),
				pick_operand(), pick_operand(), 8'($urandom_range(0, 255)));
			sent++;
		end
		if (pick < 9 || (pick >= 14 && pick < 18)) begin
			send_instr(5'($urandom_range(cab_pkg::OP_BR, cab_pkg::OP_BCS)),
				pick_operand(), pick_operand(), 8'($urandom_range(0, 255)));
			sent++;
		end
		if (pick >= 18) begin
			case ($urandom_range(0, 9))
				0: ctl = cab_pkg::OP_HALT;
				1: ctl = cab_pkg::OP_RESET;
				2, 3, 4, 5: ctl = cab_pkg::OP_WAIT;
				default: ctl = cab_pkg::OP_NOP;
			endcase
			send_instr(ctl, pick_operand(), pick_operand(), 8'($urandom_range(0, 255)));
			sent++;
		end
	endtask

	// Word add, subtract and compare at the overflow and carry boundaries.
	task automatic test_word_arith();
		send_instr(cab_pkg::OP_ADD, 16'h7FFF, 16'h0001, 8'sd0);
		send_instr(cab_pkg::OP_ADD, 16'hFFFF, 16'h0001, 8'sd127);
		send_instr(cab_pkg::OP_SUB, 16'h0001, 16'h0000, -8'sd128);
		send_instr(cab_pkg::OP_CMP, 16'h8000, 16'h0001, 8'sd0);
	endtask

	// Byte forms ignore the high bytes and round the pc up to even.
	task automatic test_byte_ops();
		send_instr(cab_pkg::OP_ADDB, 16'hFF7F, 16'hAB01, 8'sd1);
		send_instr(cab_pkg::OP_SUBB, 16'h0001, 16'h1200, 8'sd0);
		send_instr(cab_pkg::OP_MOVB, 16'h3480, 16'hFFFF, 8'sd2);
		send_instr(cab_pkg::OP_CMPB, 16'h0080, 16'h0001, -8'sd1);
	endtask

	// Logic operations clear V and keep C.
	task automatic test_logic_ops();
		send_instr(cab_pkg::OP_MOV, 16'h0000, 16'hFFFF, 8'sd0);
		send_instr(cab_pkg::OP_BIT, 16'hFFFF, 16'h8000, 8'sd4);
		send_instr(cab_pkg::OP_BIC, 16'hFFFF, 16'hFFFF, 8'sd0);
		send_instr(cab_pkg::OP_BIS, 16'h8000, 16'h0001, 8'sd2);
	endtask

	// Every branch after a compare that leaves N and C set, alternating between the two offset extremes.
	task automatic test_branches();
		logic [4:0] op;
		send_instr(cab_pkg::OP_CMP, 16'h0000, 16'h0001, 8'sd0);
		for (op = cab_pkg::OP_BR; op <= cab_pkg::OP_BCS; op++) begin
			send_instr(op, 16'h0000, 16'h0000, op[0] ? 8'sd127 : -8'sd128);
		end
	endtask

	// Nop, wait, reset and halt; halt comes last since its priority bits stick.
	task automatic test_control_ops();
		send_instr(cab_pkg::OP_NOP, 16'hFFFF, 16'hFFFF, 8'sd127);
		send_instr(cab_pkg::OP_WAIT, 16'h0000, 16'h0000, -8'sd128);
		send_instr(cab_pkg::OP_RESET, 16'h1234, 16'h5678, 8'sd5);
		send_instr(cab_pkg::OP_HALT, 16'h0000, 16'h0000, 8'sd0);
	endtask

	// Random program fragments; idling on both channels follows the idling flag.
	task automatic test_random_programs(input int count);
		int total, sent;
		total = 0;
		while (total < count) begin
			send_random_fragment(sent);
			total += sent;
		end
	endtask

	// Reports one field of a retired beat against its prediction.
	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS) begin
				$display("Mismatch on %s at beat %0d: expected %h, got %h",
					fname, beat_count, want, got);
			end
		end
	endtask

	// Compares each retired beat with the oldest prediction.
	always @(posedge clk) begin
		retire_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (retire_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("Unexpected beat %0d: value %h pc %h status %h",
						beat_count, result_value, next_pc, status_out);
				end
			end else begin
				want = retire_q.pop_front();
				check_field("result_value", want.value, result_value);
				check_field("write_back", {15'd0, want.wb}, {15'd0, write_back});
				check_field("next_pc", want.npc, next_pc);
				check_field("branch_taken", {15'd0, want.taken}, {15'd0, branch_taken});
				check_field("status_out", {8'd0, want.psw}, {8'd0, status_out});
			end
			beat_count++;
		end
	end

	// Receiver stalls in random bursts, with quiet stretches in between.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idling) begin
				case ($urandom_range(0, 7))
					0, 1: begin
						out_stall <= 1'b1;
						repeat ($urandom_range(1, 14)) @(negedge clk);
						out_stall <= 1'b0;
					end
					2: repeat ($urandom_range(10, 40)) @(negedge clk);
					default: ;
				endcase
			end
		end
	end

	// Timeout guard.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = cab_pkg::OP_NOP;
		src_value = 16'h0000;
		dst_value = 16'h0000;
		pc_adjust = 8'sd0;
		arch_pc = 16'h0000;
		arch_psw = 8'h00;
		mismatch_count = 0;
		beat_count = 0;
		idling = 1'b1;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_word_arith();
		test_byte_ops();
		test_logic_ops();
		test_branches();
		test_control_ops();
		test_random_programs(500);
		// Back-to-back beats with no idling on either side.
		idling = 1'b0;
		test_random_programs(150);

		in_valid <= 1'b0;
		while (retire_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && retire_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
